// ===== rtl/pdp_pkg.sv =====
// Shared types, constants and codes for the pad direction and auto-repeat block.
// No dependencies; every other file except pdp_ram imports this package.
`timescale 1ns / 1ps

package pdp_pkg;

  localparam int PDP_PAD_COUNT     = 4;
  localparam int PDP_HISTORY_DEPTH = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam int WORD_W  = 24;
  localparam int BTN_W   = 16;
  localparam int STICK_W = 8;
  localparam int AGE_W   = 5;
  localparam int THR_W   = 7;
  localparam int DELAY_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [WORD_W-1:0] DIR_MASK = 24'hFF0000;
  localparam logic [WORD_W-1:0] BTN_MASK = 24'h00FFFF;

  localparam logic [THR_W-1:0]   THR_RESET   = 7'd30;
  localparam logic [DELAY_W-1:0] FIRST_RESET = 8'd16;
  localparam logic [DELAY_W-1:0] NEXT_RESET  = 8'd8;
  localparam logic [DELAY_W-1:0] COUNT_MAX   = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_STICK_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_REPEAT_DELAY  = 2'd2;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_REPEAT
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } op_kind_e;

  typedef struct packed {
    logic [THR_W-1:0]   stick_threshold;
    logic [DELAY_W-1:0] first_repeat_delay;
    logic [DELAY_W-1:0] next_repeat_delay;
  } cfg_t;

  typedef struct packed {
    op_kind_e          kind;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] prs;
    logic [WORD_W-1:0] hld;
    logic [WORD_W-1:0] rel;
    logic [WORD_W-1:0] mask;
  } op_t;

  localparam int OP_W = $bits(op_t);

endpackage

// ===== rtl/pdp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pdp_queue.sv =====
// Small FIFO between the front and back parts.
// Depends on pdp_pkg for the queue depth.
`timescale 1ns / 1ps

module pdp_queue
  import pdp_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    ptr_inc = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (32'(count_q) == QUEUE_DEPTH);
  assign valid_o = (count_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/pdp_front.sv =====
// Front part: classifies transactions, forms direction, edge and repeat words,
// keeps per-pad state and emits one history operation. Depends on pdp_pkg.
`timescale 1ns / 1ps

module pdp_front
  import pdp_pkg::*;
#(
  parameter int PAD_COUNT     = PDP_PAD_COUNT,
  parameter int HISTORY_DEPTH = PDP_HISTORY_DEPTH,
  parameter int ADDR_W        = $clog2(PAD_COUNT * HISTORY_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               accept_i,
  input  logic               command_i,
  input  logic [1:0]         pad_index_i,
  input  logic [BTN_W-1:0]   buttons_i,
  input  logic [STICK_W-1:0] main_x_i,
  input  logic [STICK_W-1:0] main_y_i,
  input  logic [STICK_W-1:0] second_x_i,
  input  logic [STICK_W-1:0] second_y_i,
  input  logic [BTN_W-1:0]   system_held_i,
  input  logic [BTN_W-1:0]   system_pressed_i,
  input  logic [BTN_W-1:0]   system_released_i,
  input  logic [AGE_W-1:0]   history_age_i,
  input  logic [WORD_W-1:0]  query_mask_i,
  output op_t                op_o,
  output logic [ADDR_W-1:0]  addr_o
);

  localparam int PAD_W  = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);

  logic [WORD_W-1:0]  last_cur_q [PAD_COUNT];
  logic [WORD_W-1:0]  rel_q      [PAD_COUNT];
  logic [SLOT_W-1:0]  newest_q   [PAD_COUNT];
  phase_e             phase_q    [PAD_COUNT];
  logic [DELAY_W-1:0] count_q    [PAD_COUNT];

  logic [WORD_W-1:0]  cur_d, prs_d, hld_d, rel_d;
  logic [SLOT_W-1:0]  newest_d;
  phase_e             phase_d;
  logic [DELAY_W-1:0] count_d;

  logic               pad_ok;
  logic [PAD_W-1:0]   pad_sel;
  logic [WORD_W-1:0]  prev;
  logic [7:0]         dir;
  logic signed [8:0]  thr_pos, thr_neg;
  logic [DELAY_W-1:0] count_inc, delay;
  logic [SLOT_W-1:0]  age_c, read_slot, slot;
  logic               do_update;

  function automatic logic at_or_above(logic [STICK_W-1:0] v, logic signed [8:0] t);
    at_or_above = $signed({v[STICK_W-1], v}) >= t;
  endfunction

  function automatic logic at_or_below(logic [STICK_W-1:0] v, logic signed [8:0] t);
    at_or_below = $signed({v[STICK_W-1], v}) <= t;
  endfunction

  always_comb begin
    pad_ok  = (32'(pad_index_i) < PAD_COUNT);
    pad_sel = PAD_W'(pad_index_i);
    prev    = last_cur_q[pad_sel];

    thr_pos = $signed({2'b00, cfg_i.stick_threshold});
    thr_neg = -thr_pos;
    dir[0]  = at_or_above(main_y_i, thr_pos);
    dir[1]  = at_or_below(main_y_i, thr_neg);
    dir[2]  = at_or_below(main_x_i, thr_neg);
    dir[3]  = at_or_above(main_x_i, thr_pos);
    dir[4]  = at_or_above(second_y_i, thr_pos);
    dir[5]  = at_or_below(second_y_i, thr_neg);
    dir[6]  = at_or_below(second_x_i, thr_neg);
    dir[7]  = at_or_above(second_x_i, thr_pos);

    cur_d = {dir, buttons_i};
    prs_d = {8'h00, system_pressed_i} | (cur_d & ~prev & DIR_MASK);
    rel_d = {8'h00, system_released_i} | (prev & ~cur_d & DIR_MASK);
    hld_d = {8'h00, system_held_i};

    count_inc = (count_q[pad_sel] == COUNT_MAX) ? count_q[pad_sel]
                                                : count_q[pad_sel] + DELAY_W'(1);
    delay     = (phase_q[pad_sel] == PH_FIRST) ? cfg_i.first_repeat_delay
                                               : cfg_i.next_repeat_delay;
    phase_d   = phase_q[pad_sel];
    count_d   = count_inc;

    if (cur_d == '0) begin
      hld_d   = '0;
      phase_d = PH_IDLE;
      count_d = '0;
    end else if (cur_d == prev) begin
      if (count_inc >= delay) begin
        hld_d   = hld_d | (cur_d & DIR_MASK);
        phase_d = PH_REPEAT;
        count_d = '0;
      end
    end else begin
      hld_d   = hld_d | (cur_d & ~prev & DIR_MASK);
      phase_d = PH_FIRST;
      count_d = '0;
    end

    newest_d = (32'(newest_q[pad_sel]) == HISTORY_DEPTH - 1) ? '0
                                                             : newest_q[pad_sel] + SLOT_W'(1);

    age_c = (32'(history_age_i) >= HISTORY_DEPTH) ? SLOT_W'(HISTORY_DEPTH - 1)
                                                   : SLOT_W'(history_age_i);
    if (newest_q[pad_sel] >= age_c) begin
      read_slot = newest_q[pad_sel] - age_c;
    end else begin
      read_slot = SLOT_W'(32'(newest_q[pad_sel]) + HISTORY_DEPTH - 32'(age_c));
    end

    do_update = accept_i && pad_ok && (command_i == CMD_UPDATE);

    op_o.mask = query_mask_i;
    op_o.cur  = '0;
    op_o.prs  = '0;
    op_o.hld  = '0;
    op_o.rel  = '0;
    op_o.kind = OP_NONE;
    slot      = read_slot;
    if (pad_ok) begin
      if (command_i == CMD_UPDATE) begin
        op_o.kind = OP_WRITE;
        op_o.cur  = cur_d;
        op_o.prs  = prs_d;
        op_o.hld  = hld_d;
        op_o.rel  = rel_d;
        slot      = newest_d;
      end else begin
        op_o.kind = OP_READ;
        op_o.rel  = (history_age_i == '0) ? rel_q[pad_sel] : '0;
      end
    end
    addr_o = ADDR_W'(32'(pad_sel) * HISTORY_DEPTH + 32'(slot));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        last_cur_q[p] <= '0;
        rel_q[p]      <= '0;
        newest_q[p]   <= '0;
        phase_q[p]    <= PH_IDLE;
        count_q[p]    <= '0;
      end
    end else if (do_update) begin
      last_cur_q[pad_sel] <= cur_d;
      rel_q[pad_sel]      <= rel_d;
      newest_q[pad_sel]   <= newest_d;
      phase_q[pad_sel]    <= phase_d;
      count_q[pad_sel]    <= count_d;
    end
  end

endmodule

// ===== rtl/pdp_back.sv =====
// Back part: carries out history writes and reads and holds the result register.
// Depends on pdp_pkg and pdp_ram.
`timescale 1ns / 1ps

module pdp_back
  import pdp_pkg::*;
#(
  parameter int PAD_COUNT     = PDP_PAD_COUNT,
  parameter int HISTORY_DEPTH = PDP_HISTORY_DEPTH,
  parameter int ADDR_W        = $clog2(PAD_COUNT * HISTORY_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  op_t               op_i,
  input  logic [ADDR_W-1:0] addr_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] current_word_o,
  output logic [WORD_W-1:0] pressed_word_o,
  output logic [WORD_W-1:0] held_word_o,
  output logic [WORD_W-1:0] released_word_o
);

  localparam int TOTAL = PAD_COUNT * HISTORY_DEPTH;
  localparam int ROW_W = 3 * WORD_W;

  logic [TOTAL-1:0] written_q, written_d;
  logic             out_valid_q, out_valid_d;
  op_t              op_q;
  logic             hit_q;
  logic             ram_we, ram_re;
  logic [ROW_W-1:0] ram_rdata;
  logic [WORD_W-1:0] cur, prs, hld;

  pdp_ram #(
    .WIDTH(ROW_W),
    .DEPTH(TOTAL)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_i),
    .wdata_i({op_i.hld, op_i.prs, op_i.cur}),
    .re_i   (ram_re),
    .raddr_i(addr_i),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    pop_o       = op_valid_i && (!out_valid_q || !out_stall_i);
    ram_we      = pop_o && (op_i.kind == OP_WRITE);
    ram_re      = pop_o && (op_i.kind == OP_READ);
    written_d   = written_q;
    if (ram_we) begin
      written_d[addr_i] = 1'b1;
    end
    out_valid_d = pop_o ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q  <= op_i;
      hit_q <= written_q[addr_i];
    end
  end

  always_comb begin
    if (op_q.kind == OP_READ) begin
      cur = hit_q ? ram_rdata[WORD_W-1:0]          : '0;
      prs = hit_q ? ram_rdata[2*WORD_W-1:WORD_W]   : '0;
      hld = hit_q ? ram_rdata[3*WORD_W-1:2*WORD_W] : '0;
    end else begin
      cur = op_q.cur;
      prs = op_q.prs;
      hld = op_q.hld;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_word_o  = cur & op_q.mask;
  assign pressed_word_o  = prs & op_q.mask;
  assign held_word_o     = hld & op_q.mask;
  assign released_word_o = op_q.rel & op_q.mask;

endmodule

// ===== rtl/pad_direction_and_autorepeat.sv =====
// Top level: configuration registers, front part, operation queue and back part.
// Depends on pdp_pkg, pdp_front, pdp_queue, pdp_back and pdp_ram.
//
//   channel   handshake              payload
//   in        in_valid_i/in_stall_o  command_i .. query_mask_i
//   out       out_valid_o/out_stall_i current_word_o .. released_word_o
//   cfg       cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One transaction a cycle is sustained while out_stall_i is low; the front settles
// an update or read in its accept cycle and the back does one history RAM access a
// cycle (one write port, one registered read port). An accepted transaction passes
// through the queue into the result register and is held there until taken.
// Reset clears per-pad state and history valid bits at once; no clearing pass.
// in_stall_o rises only when the two-entry queue is full; out_stall_i holds the
// result register and the queue absorbs up to two more transactions.
`timescale 1ns / 1ps

module pad_direction_and_autorepeat
  import pdp_pkg::*;
#(
  parameter int PAD_COUNT     = PDP_PAD_COUNT,
  parameter int HISTORY_DEPTH = PDP_HISTORY_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [1:0]            pad_index_i,
  input  logic [BTN_W-1:0]      buttons_i,
  input  logic [STICK_W-1:0]    main_x_i,
  input  logic [STICK_W-1:0]    main_y_i,
  input  logic [STICK_W-1:0]    second_x_i,
  input  logic [STICK_W-1:0]    second_y_i,
  input  logic [BTN_W-1:0]      system_held_i,
  input  logic [BTN_W-1:0]      system_pressed_i,
  input  logic [BTN_W-1:0]      system_released_i,
  input  logic [AGE_W-1:0]      history_age_i,
  input  logic [WORD_W-1:0]     query_mask_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [WORD_W-1:0]     current_word_o,
  output logic [WORD_W-1:0]     pressed_word_o,
  output logic [WORD_W-1:0]     held_word_o,
  output logic [WORD_W-1:0]     released_word_o
);

  localparam int ADDR_W = $clog2(PAD_COUNT * HISTORY_DEPTH);
  localparam int ENTRY_W = ADDR_W + OP_W;

  cfg_t              cfg_q, cfg_d;
  logic              accept;
  logic              q_full, q_valid, q_pop;
  op_t               front_op, back_op;
  logic [ADDR_W-1:0] front_addr, back_addr;
  logic [ENTRY_W-1:0] q_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STICK_THRESHOLD:    cfg_d.stick_threshold    = cfg_wdata_i[THR_W-1:0];
        REG_FIRST_REPEAT_DELAY: cfg_d.first_repeat_delay = cfg_wdata_i[DELAY_W-1:0];
        REG_NEXT_REPEAT_DELAY:  cfg_d.next_repeat_delay  = cfg_wdata_i[DELAY_W-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stick_threshold    <= THR_RESET;
      cfg_q.first_repeat_delay <= FIRST_RESET;
      cfg_q.next_repeat_delay  <= NEXT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  pdp_front #(
    .PAD_COUNT    (PAD_COUNT),
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .accept_i         (accept),
    .command_i        (command_i),
    .pad_index_i      (pad_index_i),
    .buttons_i        (buttons_i),
    .main_x_i         (main_x_i),
    .main_y_i         (main_y_i),
    .second_x_i       (second_x_i),
    .second_y_i       (second_y_i),
    .system_held_i    (system_held_i),
    .system_pressed_i (system_pressed_i),
    .system_released_i(system_released_i),
    .history_age_i    (history_age_i),
    .query_mask_i     (query_mask_i),
    .op_o             (front_op),
    .addr_o           (front_addr)
  );

  pdp_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i({front_addr, front_op}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  assign back_addr = q_rdata[ENTRY_W-1:OP_W];
  assign back_op   = op_t'(q_rdata[OP_W-1:0]);

  pdp_back #(
    .PAD_COUNT    (PAD_COUNT),
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (q_valid),
    .op_i           (back_op),
    .addr_i         (back_addr),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_word_o (current_word_o),
    .pressed_word_o (pressed_word_o),
    .held_word_o    (held_word_o),
    .released_word_o(released_word_o)
  );

endmodule
